// File: design/tcss_pkg.sv
// ----------------------------------------------------------------------------
// tcss_pkg
// Shared types, character codes and the tail-stage function of the text
// comment and space stripper.
// ----------------------------------------------------------------------------
package tcss_pkg;

  // Character codes
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_ZERO   = 8'h00;

  // Result queue sizing: one item makes at most three results
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Flags of the space, empty-line and terminator stages
  typedef struct packed {
    logic seen_nonspace;
    logic seen_nonnewline;
    logic quote_open_last;
  } tail_state_t;

  typedef struct packed {
    tail_state_t st;
    logic        keep;
    logic [7:0]  ch;
  } tail_res_t;

  // Run one byte through the space, empty-line and terminator stages
  function automatic tail_res_t tail_step(input tail_state_t st_in, input logic [7:0] c);
    tail_res_t r;
    r.st   = st_in;
    r.keep = 1'b1;
    r.ch   = c;
    // drop leading and repeated spaces
    if (c == CH_NL) begin
      r.st.seen_nonspace = 1'b0;
    end else if (c == CH_SPACE) begin
      if (!st_in.seen_nonspace) begin
        r.keep = 1'b0;
      end
      r.st.seen_nonspace = 1'b0;
    end else begin
      r.st.seen_nonspace = 1'b1;
    end
    // drop empty lines
    if (r.keep) begin
      if (c != CH_NL) begin
        r.st.seen_nonnewline = 1'b1;
      end else if (!st_in.seen_nonnewline) begin
        r.keep = 1'b0;
      end else begin
        r.st.seen_nonnewline = 1'b0;
      end
    end
    // terminate lines outside quotes
    if (r.keep) begin
      if (c == CH_QUOTE) begin
        r.st.quote_open_last = !st_in.quote_open_last;
      end else if (c == CH_NL && !st_in.quote_open_last) begin
        r.ch = CH_ZERO;
      end
    end
    // a dropped space leaves all flags as they were
    if (!r.keep && c == CH_SPACE) begin
      r.st = st_in;
    end
    return r;
  endfunction

endpackage

// File: design/text_comment_space_stripper_top.sv
// ----------------------------------------------------------------------------
// text_comment_space_stripper_top
// Streaming text preprocessor: drops comments, rewrites quoted newlines and
// escapes, squeezes spaces and empty lines, and terminates lines with zero.
// ----------------------------------------------------------------------------
//  channel | signals                            | direction
//  --------+------------------------------------+----------
//  input   | in_valid, in_ready, in_char, in_last    | in
//  output  | out_valid, out_ready, out_char, out_last | out
//
//  An accepted byte is processed in the cycle it is taken; its zero to three
//  results land in a four-entry result queue and leave one per cycle unless
//  out_ready stalls. One byte per cycle is sustained while each byte makes
//  at most one result and out_ready stays high; the queue drain port sets
//  the rate otherwise. in_ready is high while the queue holds at most one
//  result. Synchronous reset clears all flags and empties the queue.
// ----------------------------------------------------------------------------
module text_comment_space_stripper_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last
);

  // Stream state
  logic                quote_open_first, quote_open_first_next;
  logic                in_comment, in_comment_next;
  logic                quote_open_later, quote_open_later_next;
  logic [7:0]          previous_raw_char, previous_raw_char_next;
  logic [7:0]          held_char, held_char_next;
  logic                held_valid, held_valid_next;
  tcss_pkg::tail_state_t tail_st, tail_st_next;

  // Result queue
  logic [7:0]                 q_char [tcss_pkg::QUEUE_DEPTH];
  logic                       q_last [tcss_pkg::QUEUE_DEPTH];
  logic [tcss_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [tcss_pkg::CNT_W-1:0] count;

  // Results of the current beat
  logic [7:0] res_char [tcss_pkg::MAX_RESULTS];
  logic       res_last [tcss_pkg::MAX_RESULTS];
  logic [1:0] n_res;

  logic in_fire, out_fire;

  assign in_ready  = (count <= tcss_pkg::CNT_W'(1));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_fire  = out_valid && out_ready;
  assign out_char  = q_char[rd_ptr];
  assign out_last  = q_last[rd_ptr];

  // Process one byte through all stages
  always_comb begin
    logic [7:0]          c;
    logic                pass;
    tcss_pkg::tail_res_t tr;
    quote_open_first_next  = quote_open_first;
    in_comment_next        = in_comment;
    quote_open_later_next  = quote_open_later;
    previous_raw_char_next = previous_raw_char;
    held_char_next         = held_char;
    held_valid_next        = held_valid;
    tail_st_next           = tail_st;
    n_res                  = 2'd0;
    for (int k = 0; k < tcss_pkg::MAX_RESULTS; k++) begin
      res_char[k] = tcss_pkg::CH_ZERO;
      res_last[k] = 1'b0;
    end
    c    = in_char;
    pass = 1'b1;
    tr   = '0;

    // strip comments outside quotes
    if (in_comment) begin
      if (c == tcss_pkg::CH_NL) begin
        in_comment_next = 1'b0;
      end else begin
        pass = 1'b0;
      end
    end else if (c == tcss_pkg::CH_HASH && !quote_open_first) begin
      in_comment_next = 1'b1;
      pass = 1'b0;
    end else if (c == tcss_pkg::CH_QUOTE) begin
      quote_open_first_next = !quote_open_first;
    end

    // rewrite quoted newlines and escapes, holding one byte
    if (pass) begin
      if (c == tcss_pkg::CH_NL && quote_open_later) begin
        c = tcss_pkg::CH_SPACE;
      end
      if (c == tcss_pkg::CH_N && quote_open_later &&
          previous_raw_char == tcss_pkg::CH_BSLASH) begin
        held_char_next = tcss_pkg::CH_NL;
      end else begin
        if (held_valid) begin
          tr = tcss_pkg::tail_step(tail_st_next, held_char);
          tail_st_next = tr.st;
          if (tr.keep) begin
            res_char[n_res] = tr.ch;
            n_res = n_res + 2'd1;
          end
        end
        held_char_next = c;
      end
      held_valid_next = 1'b1;
      if (c == tcss_pkg::CH_QUOTE) begin
        quote_open_later_next = !quote_open_later;
      end
      previous_raw_char_next = c;
    end

    // flush the held byte and close the text
    if (in_last) begin
      if (held_valid_next) begin
        tr = tcss_pkg::tail_step(tail_st_next, held_char_next);
        if (tr.keep) begin
          res_char[n_res] = tr.ch;
          n_res = n_res + 2'd1;
        end
      end
      res_char[n_res] = tcss_pkg::CH_ZERO;
      res_last[n_res] = 1'b1;
      n_res = n_res + 2'd1;
      quote_open_first_next  = 1'b0;
      in_comment_next        = 1'b0;
      quote_open_later_next  = 1'b0;
      previous_raw_char_next = tcss_pkg::CH_N;
      held_char_next         = tcss_pkg::CH_ZERO;
      held_valid_next        = 1'b0;
      tail_st_next           = '0;
    end
  end

  // Advance stream state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_open_first  <= 1'b0;
      in_comment        <= 1'b0;
      quote_open_later  <= 1'b0;
      previous_raw_char <= tcss_pkg::CH_N;
      held_char         <= tcss_pkg::CH_ZERO;
      held_valid        <= 1'b0;
      tail_st           <= '0;
    end else if (in_fire) begin
      quote_open_first  <= quote_open_first_next;
      in_comment        <= in_comment_next;
      quote_open_later  <= quote_open_later_next;
      previous_raw_char <= previous_raw_char_next;
      held_char         <= held_char_next;
      held_valid        <= held_valid_next;
      tail_st           <= tail_st_next;
    end
  end

  // Push results into the queue
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < tcss_pkg::MAX_RESULTS; k++) begin
        if (2'(k) < n_res) begin
          q_char[wr_ptr + tcss_pkg::PTR_W'(k)] <= res_char[k];
          q_last[wr_ptr + tcss_pkg::PTR_W'(k)] <= res_last[k];
        end
      end
    end
  end

  // Track queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + tcss_pkg::PTR_W'(n_res);
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + tcss_pkg::PTR_W'(1);
      end
      count <= count + (in_fire ? tcss_pkg::CNT_W'(n_res) : '0)
                     - (out_fire ? tcss_pkg::CNT_W'(1) : '0);
    end
  end

  // Checks
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= tcss_pkg::CNT_W'(tcss_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_last_clears : assert property (@(posedge clk) disable iff (rst)
    in_fire && in_last |=> !held_valid && !in_comment && !quote_open_later)
    else $error("state not cleared after last beat");

  a_last_queued : assert property (@(posedge clk) disable iff (rst)
    in_fire && in_last |=> out_valid)
    else $error("terminator missing after last beat");

  a_hold_idle : assert property (@(posedge clk) disable iff (rst)
    !in_fire && !out_fire |=> $stable(count) && $stable(held_valid))
    else $error("queue or hold changed without a beat");

endmodule

// File: tb/text_comment_space_stripper_top_tb.sv
// ----------------------------------------------------------------------------
// text_comment_space_stripper_top_tb
// Self-checking bench for the text stripper. A scoreboard class tracks
// comment, quote, escape, space and empty-line state for each byte taken. It
// queues the bytes the block should emit and compares every output beat, in
// order, against that queue. Stimulus is short directed texts followed by
// random texts built mostly from the block's special characters. Both
// channels stall at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module text_comment_space_stripper_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: byte-level predictor plus queue of expected output beats
  class stripper_scoreboard;
    logic       quote_first;
    logic       comment_on;
    logic       quote_mid;
    logic [7:0] prev_char;
    logic [7:0] held_char;
    logic       held_on;
    logic       after_text;
    logic       after_char;
    logic       quote_tail;
    logic [7:0] want_char[$];
    logic       want_last[$];
    int         errors;

    function void clear();
      quote_first = 1'b0;
      comment_on  = 1'b0;
      quote_mid   = 1'b0;
      prev_char   = tcss_pkg::CH_N;
      held_char   = tcss_pkg::CH_ZERO;
      held_on     = 1'b0;
      after_text  = 1'b0;
      after_char  = 1'b0;
      quote_tail  = 1'b0;
    endfunction

    // Squeeze spaces, drop empty lines, terminate unquoted lines
    function void squeeze(input logic [7:0] c);
      logic [7:0] ch;
      ch = c;
      if (ch == tcss_pkg::CH_NL) begin
        after_text = 1'b0;
      end else if (ch == tcss_pkg::CH_SPACE) begin
        if (!after_text) return;
        after_text = 1'b0;
      end else begin
        after_text = 1'b1;
      end
      if (ch != tcss_pkg::CH_NL) begin
        after_char = 1'b1;
      end else begin
        if (!after_char) return;
        after_char = 1'b0;
      end
      if (ch == tcss_pkg::CH_QUOTE) begin
        quote_tail = !quote_tail;
      end else if (ch == tcss_pkg::CH_NL && !quote_tail) begin
        ch = tcss_pkg::CH_ZERO;
      end
      want_char.push_back(ch);
      want_last.push_back(1'b0);
    endfunction

    // Take one accepted input beat and queue what it produces
    function void note_byte(input logic [7:0] c_in, input logic last);
      logic [7:0] c;
      logic       keep;
      c    = c_in;
      keep = 1'b1;
      // strip comments outside quotes, keep the closing newline
      if (comment_on) begin
        if (c == tcss_pkg::CH_NL) comment_on = 1'b0;
        else keep = 1'b0;
      end else if (c == tcss_pkg::CH_HASH && !quote_first) begin
        comment_on = 1'b1;
        keep = 1'b0;
      end else if (c == tcss_pkg::CH_QUOTE) begin
        quote_first = !quote_first;
      end
      // quoted newline to space, quoted backslash-n to newline
      if (keep) begin
        if (c == tcss_pkg::CH_NL && quote_mid) c = tcss_pkg::CH_SPACE;
        if (c == tcss_pkg::CH_N && quote_mid && prev_char == tcss_pkg::CH_BSLASH) begin
          held_char = tcss_pkg::CH_NL;
          held_on   = 1'b1;
        end else begin
          if (held_on) squeeze(held_char);
          held_char = c;
          held_on   = 1'b1;
        end
        if (c == tcss_pkg::CH_QUOTE) quote_mid = !quote_mid;
        prev_char = c;
      end
      // flush and close the text
      if (last) begin
        if (held_on) squeeze(held_char);
        want_char.push_back(tcss_pkg::CH_ZERO);
        want_last.push_back(1'b1);
        clear();
      end
    endfunction

    function void check_beat(input logic [7:0] c, input logic last);
      logic [7:0] ec;
      logic       el;
      if (want_char.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual char %02h last %0b",
                 $time, c, last);
        errors++;
        return;
      end
      ec = want_char.pop_front();
      el = want_last.pop_front();
      if (c !== ec) begin
        $display("%0t: out_char mismatch, expected %02h, actual %02h", $time, ec, c);
        errors++;
      end
      if (last !== el) begin
        $display("%0t: out_last mismatch, expected %0b, actual %0b", $time, el, last);
        errors++;
      end
    endfunction

    function int pending();
      return want_char.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_char;
  logic       in_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_char;
  logic       out_last;

  stripper_scoreboard sb;
  bit gaps_on;
  int bytes_sent;

  text_comment_space_stripper_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_char   (in_char),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(in_char, in_last);
      if (out_valid && out_ready) sb.check_beat(out_char, out_last);
    end
  end

  // Stall the output side at random
  always @(negedge clk) begin
    if (gaps_on) out_ready <= ($urandom_range(99) >= 33);
    else out_ready <= 1'b1;
  end

  // Send one byte; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] c, input logic last);
    if (gaps_on) begin
      while ($urandom_range(99) < 33) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_char  <= c;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Random byte weighted toward the characters the block reacts to
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 45) return tcss_pkg::CH_SPACE;
    if (r < 57) return tcss_pkg::CH_NL;
    if (r < 62) return tcss_pkg::CH_HASH;
    if (r < 70) return tcss_pkg::CH_QUOTE;
    if (r < 76) return tcss_pkg::CH_BSLASH;
    if (r < 82) return tcss_pkg::CH_N;
    if (r < 85) return 8'h09;
    return 8'($urandom_range(1, 255));
  endfunction

  // Hard stop
  initial begin
    #400000;
    $display("text_comment_space_stripper_top_tb: errors");
    $finish;
  end

  initial begin
    logic [7:0] text_a[$];
    logic [7:0] text_b[$];
    int         len;
    int         waited;
    int         texts;

    sb = new();
    sb.clear();
    sb.errors = 0;
    gaps_on    = 1'b1;
    bytes_sent = 0;
    texts      = 0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_char   = 8'h01;
    in_last   = 1'b0;
    out_ready = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: leading and repeated spaces, comment holding a quote, comment
    // end, empty line, quoted escape and newline, tab, byte extremes
    text_a = '{tcss_pkg::CH_SPACE, 8'h61, tcss_pkg::CH_SPACE, tcss_pkg::CH_SPACE,
               tcss_pkg::CH_HASH, tcss_pkg::CH_QUOTE, 8'h63, tcss_pkg::CH_NL,
               tcss_pkg::CH_NL, tcss_pkg::CH_QUOTE, 8'h78, tcss_pkg::CH_BSLASH,
               tcss_pkg::CH_N, tcss_pkg::CH_NL, 8'h79, tcss_pkg::CH_QUOTE,
               8'h09, 8'hFF, 8'h80};
    foreach (text_a[i]) send_byte(text_a[i], i == text_a.size() - 1);
    // hash inside quotes, backslash-n outside quotes, then one-byte texts
    text_b = '{tcss_pkg::CH_QUOTE, tcss_pkg::CH_HASH, tcss_pkg::CH_BSLASH,
               tcss_pkg::CH_N, tcss_pkg::CH_QUOTE, tcss_pkg::CH_BSLASH,
               tcss_pkg::CH_N};
    foreach (text_b[i]) send_byte(text_b[i], i == text_b.size() - 1);
    send_byte(tcss_pkg::CH_NL, 1'b1);
    send_byte(8'h7F, 1'b1);

    // Random texts, one stretch at full rate on both sides
    while (bytes_sent < 255) begin
      gaps_on = !(texts >= 4 && texts < 8);
      len = $urandom_range(1, 36);
      for (int i = 0; i < len; i++) send_byte(pick_char(), i == len - 1);
      texts++;
    end
    in_valid <= 1'b0;
    gaps_on = 1'b1;

    // Drain, then let any stray beat show up
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, sb.pending());
      sb.errors++;
    end
    repeat (16) @(negedge clk);

    if (sb.errors == 0) begin
      $display("text_comment_space_stripper_top_tb: clean");
    end else begin
      $display("text_comment_space_stripper_top_tb: errors");
    end
    $finish;
  end

endmodule
